/* hw/rtl/mrb_pkg.sv */
package mrb_pkg;

   localparam int NUM_MODES   = 10;
   localparam int STATE_WIDTH = 32;

   localparam int FRAC_BITS  = STATE_WIDTH - 4;
   localparam int COEF_FRAC  = 28;
   localparam int IDX_W      = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
   localparam int FORCE_W    = 24;
   localparam int COEF_W     = 32;
   localparam int OUT_W      = 32;
   localparam int MODE_W     = 2;
   localparam int SEL_W      = 2;
   localparam int MIDX_W     = 5;

   // shared multiplier operands: a holds state or force, b holds a coefficient or force_scale
   localparam int MA_W     = (STATE_WIDTH > FORCE_W) ? STATE_WIDTH : FORCE_W;
   localparam int MB_W     = COEF_W + 1;
   localparam int PROD_W   = MA_W + MB_W;
   localparam int FT_SHIFT = 55 - STATE_WIDTH;
   localparam int FT_W     = STATE_WIDTH + 2;
   localparam int NU_W     = MA_W + 8;
   localparam int ACC_W    = PROD_W - FRAC_BITS + $clog2(NUM_MODES) + 1;

   localparam logic signed [STATE_WIDTH-1:0] STATE_ONE = {4'b0001, {FRAC_BITS{1'b0}}};
   localparam logic signed [STATE_WIDTH-1:0] STATE_NEG_ONE = -STATE_ONE;

   localparam logic [MODE_W-1:0] REQ_FORCE = 2'd0;
   localparam logic [MODE_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] REQ_CLEAR = 2'd2;

   localparam logic [SEL_W-1:0] COEF_SPRING = 2'd0;
   localparam logic [SEL_W-1:0] COEF_DAMP   = 2'd1;
   localparam logic [SEL_W-1:0] COEF_GAIN   = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_FORCE_SCALE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MK,
      ST_MC,
      ST_UPD,
      ST_MG,
      ST_ACC,
      ST_OUT
   } mrb_state_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_WRITE,
      DP_CLEAR,
      DP_FTERM,
      DP_MUL_K,
      DP_MUL_C,
      DP_UPDATE,
      DP_MUL_G,
      DP_ACC,
      DP_LOAD_OUT
   } mrb_op_type;

   typedef struct packed {
      mrb_op_type       op;
      logic [IDX_W-1:0] idx;
      logic             first;
   } mrb_cmd_type;

   function automatic logic signed [STATE_WIDTH-1:0] sat_state(
      input logic signed [NU_W-1:0] v
   );
      logic all_one;
      logic all_zero;
      all_one  = &v[NU_W-1:STATE_WIDTH-1];
      all_zero = ~|v[NU_W-1:STATE_WIDTH-1];
      if (all_one || all_zero) begin
         return v[STATE_WIDTH-1:0];
      end else if (v[NU_W-1]) begin
         return {1'b1, {(STATE_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_WIDTH-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
      logic all_one;
      logic all_zero;
      all_one  = &v[ACC_W-1:OUT_W-1];
      all_zero = ~|v[ACC_W-1:OUT_W-1];
      if (all_one || all_zero) begin
         return v[OUT_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

endpackage

/* hw/rtl/mrb_req_if.sv */
interface mrb_req_if import mrb_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic signed [FORCE_W-1:0] force_sample;
   logic [MIDX_W-1:0]         mode_index;
   logic [SEL_W-1:0]          coef_select;
   logic signed [COEF_W-1:0]  coef_value;

   modport source (output valid, mode, force_sample, mode_index, coef_select, coef_value,
                   input ready);
   modport sink (input valid, mode, force_sample, mode_index, coef_select, coef_value,
                 output ready);
endinterface

/* hw/rtl/mrb_rsp_if.sv */
interface mrb_rsp_if import mrb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] velocity_sum;

   modport source (output valid, velocity_sum, input ready);
   modport sink (input valid, velocity_sum, output ready);
endinterface

/* hw/rtl/modal_resonator_bank.sv */
// modal resonator bank: NUM_MODES mass-spring-damper modes in Q4.28, stepped by force items.
// req_ch carries one item per valid/ready handshake; mode selects what the item does:
//   force sample     steps every mode once and yields one velocity_sum item on rsp_ch
//   coefficient write loads spring, damping or gain of one mode, no result
//   clear            zeroes all positions and velocities, coefficients are kept, no result
// A write or clear acts in its accept cycle. A force sample forms its force term in the accept
// cycle, then visits the modes in turn through one shared multiplier, with the steps spring,
// damping, update and gain per mode, then a final add and the output step. The next item is
// taken the cycle after the result is loaded; no item is taken while a force sample is being
// stepped.
// The result sits in an output register: a new item is taken while it waits, and only a
// later force result stalls in its output step until rsp_ch.ready frees the register.
// csr_* is an APB-style port, pready always high; byte address 0 holds force_scale.
// Synchronous reset zeroes force_scale, all mode state and all coefficients, and empties
// the output register.
module modal_resonator_bank import mrb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mrb_req_if.sink               req_ch,
   mrb_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [31:0] force_scale_ff, force_scale_in;
   logic        csr_write;
   mrb_cmd_type cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      force_scale_in = force_scale_ff;
      if (csr_write && csr_paddr[2] == CSR_FORCE_SCALE) begin
         force_scale_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         force_scale_ff <= '0;
      end else begin
         force_scale_ff <= force_scale_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_FORCE_SCALE) ? force_scale_ff : '0;

   mrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   mrb_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .force_scale  (force_scale_ff),
      .force_sample (req_ch.force_sample),
      .mode_index   (req_ch.mode_index),
      .coef_select  (req_ch.coef_select),
      .coef_value   (req_ch.coef_value),
      .velocity_sum (rsp_ch.velocity_sum)
   );

endmodule

/* hw/rtl/mrb_ctrl.sv */
module mrb_ctrl import mrb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mrb_cmd_type       cmd
);

   mrb_state_type    state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      logic load;
      load      = 1'b0;
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      cmd.op    = DP_IDLE;
      cmd.idx   = idx_ff;
      cmd.first = (idx_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_mode)
                  REQ_FORCE: begin
                     cmd.op   = DP_FTERM;
                     idx_in   = '0;
                     state_in = ST_MK;
                  end
                  REQ_WRITE: cmd.op = DP_WRITE;
                  REQ_CLEAR: cmd.op = DP_CLEAR;
                  default:   cmd.op = DP_IDLE;
               endcase
            end
         end
         ST_MK: begin
            cmd.op   = DP_MUL_K;
            state_in = ST_MC;
         end
         ST_MC: begin
            cmd.op   = DP_MUL_C;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.op   = DP_UPDATE;
            state_in = ST_MG;
         end
         ST_MG: begin
            cmd.op = DP_MUL_G;
            if (idx_ff == IDX_W'(NUM_MODES - 1)) begin
               state_in = ST_ACC;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MK;
            end
         end
         ST_ACC: begin
            cmd.op   = DP_ACC;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = DP_LOAD_OUT;
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   a_force_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == REQ_FORCE) |=> (state_ff == ST_MK && idx_ff == '0))
      else $error("force item did not start the mode walk at mode zero");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(idx_ff) < NUM_MODES)
      else $error("mode counter beyond the bank");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_OUT)
      else $error("result overwrote an item still waiting");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result shown outside the output step");

endmodule

/* hw/rtl/mrb_datapath.sv */
module mrb_datapath import mrb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mrb_cmd_type               cmd,
   input  logic [31:0]               force_scale,
   input  logic signed [FORCE_W-1:0] force_sample,
   input  logic [MIDX_W-1:0]         mode_index,
   input  logic [SEL_W-1:0]          coef_select,
   input  logic signed [COEF_W-1:0]  coef_value,
   output logic signed [OUT_W-1:0]   velocity_sum
);

   logic signed [STATE_WIDTH-1:0] x_ff [NUM_MODES];
   logic signed [STATE_WIDTH-1:0] u_ff [NUM_MODES];
   logic signed [COEF_W-1:0]      k_ff [NUM_MODES];
   logic signed [COEF_W-1:0]      c_ff [NUM_MODES];
   logic signed [COEF_W-1:0]      g_ff [NUM_MODES];

   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [FT_W-1:0]        fterm_ff;
   logic signed [NU_W-1:0]        sx_ff;
   logic signed [STATE_WIDTH-1:0] nu_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [OUT_W-1:0]       rsp_sum_ff;

   logic signed [MA_W-1:0]        mul_a;
   logic signed [MB_W-1:0]        mul_b;
   logic                          mul_en;
   logic signed [PROD_W-1:0]      mul_p;
   logic signed [PROD_W-1:0]      prod_shr_coef;
   logic signed [PROD_W-1:0]      prod_shr_frac;
   logic signed [PROD_W-1:0]      prod_shr_ft;
   logic signed [ACC_W-1:0]       gterm;
   logic signed [STATE_WIDTH-1:0] x_cur, u_cur;
   logic signed [NU_W-1:0]        nu_sum, x_sum;
   logic signed [STATE_WIDTH-1:0] nu_sat, x_sat, nu_new, x_new;
   logic                          blow_up;
   logic                          idx_ok;
   logic [IDX_W-1:0]              widx;

   assign x_cur = x_ff[cmd.idx];
   assign u_cur = u_ff[cmd.idx];

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      case (cmd.op)
         DP_FTERM: begin
            mul_a  = MA_W'(force_sample);
            mul_b  = signed'({1'b0, force_scale});
            mul_en = 1'b1;
         end
         DP_MUL_K: begin
            mul_a  = MA_W'(x_cur);
            mul_b  = MB_W'(k_ff[cmd.idx]);
            mul_en = 1'b1;
         end
         DP_MUL_C: begin
            mul_a  = MA_W'(u_cur);
            mul_b  = MB_W'(c_ff[cmd.idx]);
            mul_en = 1'b1;
         end
         DP_MUL_G: begin
            mul_a  = MA_W'(nu_ff);
            mul_b  = MB_W'(g_ff[cmd.idx]);
            mul_en = 1'b1;
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // products floor to the target format
   assign prod_shr_coef = prod_ff >>> COEF_FRAC;
   assign prod_shr_frac = prod_ff >>> FRAC_BITS;
   assign prod_shr_ft   = prod_ff >>> FT_SHIFT;
   assign gterm         = ACC_W'(prod_shr_frac);

   // semi-implicit euler step; the damping product sits in prod_ff here
   assign nu_sum  = NU_W'(u_cur) + NU_W'(fterm_ff) - sx_ff - NU_W'(prod_shr_coef);
   assign nu_sat  = sat_state(nu_sum);
   assign x_sum   = NU_W'(x_cur) + NU_W'(nu_sat);
   assign x_sat   = sat_state(x_sum);
   assign blow_up = (x_sat > STATE_ONE) || (x_sat < STATE_NEG_ONE);
   assign nu_new  = blow_up ? '0 : nu_sat;
   assign x_new   = blow_up ? '0 : x_sat;

   assign idx_ok = int'(mode_index) < NUM_MODES;
   assign widx   = IDX_W'(mode_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MODES; i++) begin
            x_ff[i] <= '0;
            u_ff[i] <= '0;
            k_ff[i] <= '0;
            c_ff[i] <= '0;
            g_ff[i] <= '0;
         end
      end else begin
         case (cmd.op)
            DP_WRITE: begin
               if (idx_ok) begin
                  case (coef_select)
                     COEF_SPRING: k_ff[widx] <= coef_value;
                     COEF_DAMP:   c_ff[widx] <= coef_value;
                     COEF_GAIN:   g_ff[widx] <= coef_value;
                     default: ;
                  endcase
               end
            end
            DP_CLEAR: begin
               for (int i = 0; i < NUM_MODES; i++) begin
                  x_ff[i] <= '0;
                  u_ff[i] <= '0;
               end
            end
            DP_UPDATE: begin
               x_ff[cmd.idx] <= x_new;
               u_ff[cmd.idx] <= nu_new;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_p;
      end
      case (cmd.op)
         DP_MUL_K: begin
            // mode zero picks up the force term, later modes add the previous gain term
            if (cmd.first) begin
               fterm_ff <= FT_W'(prod_shr_ft);
               acc_ff   <= '0;
            end else begin
               acc_ff <= acc_ff + gterm;
            end
         end
         DP_MUL_C:    sx_ff <= NU_W'(prod_shr_coef);
         DP_UPDATE:   nu_ff <= nu_new;
         DP_ACC:      acc_ff <= acc_ff + gterm;
         DP_LOAD_OUT: rsp_sum_ff <= sat_out(acc_ff);
         default: ;
      endcase
   end

   assign velocity_sum = rsp_sum_ff;

endmodule
